FILE: src/pgrepl_pkg.sv
// Shared types and constants for the page replacement unit.
package pgrepl_pkg;

    localparam int DEF_VIRTUAL_PAGES = 32;
    localparam int DEF_TIME_BITS     = 16;

    localparam int PAGE_IN_W   = 5;
    localparam int FRAME_W     = 5;
    localparam int FRAME_LIMIT = 32;
    localparam int FRAMES_W    = 6;
    localparam int FAULT_W     = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 6'd4;
    localparam logic [FAULT_W-1:0]  FAULT_MAX    = 16'hFFFF;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef enum logic {
        REG_POLICY_MODE   = 1'b0,
        REG_FRAMES_IN_USE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Flags of the search beat that walks down the row of page cells.
    typedef struct packed {
        logic valid;
        logic hit;
        logic lru_found;
        logic fifo_match;
    } t_scan_flags;

    // Table update broadcast to every page cell.
    typedef struct packed {
        logic clear;
        logic evict;
        logic load;
        logic stamp;
    } t_cell_wr;

endpackage

FILE: src/pgrepl_cell.sv
// One page entry of the replacement table and its stage of the search chain.
module pgrepl_cell #(
    parameter int CELL_ID = 0,
    parameter int PAGE_W  = 5,
    parameter int TIME_W  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Keys held steady by the controller for the whole search.
    input  logic [PAGE_W-1:0]               i_key_page,
    input  logic [PAGE_W-1:0]               i_fifo_page,
    input  logic [pgrepl_pkg::FRAME_W-1:0]  i_fifo_frame,
    // Search beat from the previous cell.
    input  pgrepl_pkg::t_scan_flags         i_flags,
    input  logic [pgrepl_pkg::FRAME_W-1:0]  i_hit_frame,
    input  logic [TIME_W-1:0]               i_lru_time,
    input  logic [PAGE_W-1:0]               i_lru_page,
    input  logic [pgrepl_pkg::FRAME_W-1:0]  i_lru_frame,
    // Search beat to the next cell.
    output pgrepl_pkg::t_scan_flags         o_flags,
    output logic [pgrepl_pkg::FRAME_W-1:0]  o_hit_frame,
    output logic [TIME_W-1:0]               o_lru_time,
    output logic [PAGE_W-1:0]               o_lru_page,
    output logic [pgrepl_pkg::FRAME_W-1:0]  o_lru_frame,
    // Table update.
    input  pgrepl_pkg::t_cell_wr            i_wr,
    input  logic [PAGE_W-1:0]               i_wr_page,
    input  logic [PAGE_W-1:0]               i_evict_page,
    input  logic [pgrepl_pkg::FRAME_W-1:0]  i_wr_frame,
    input  logic [TIME_W-1:0]               i_wr_time
);

    localparam logic [PAGE_W-1:0] MY_PAGE = PAGE_W'(CELL_ID);

    logic                           r_resident;
    logic [pgrepl_pkg::FRAME_W-1:0] r_frame;
    logic [TIME_W-1:0]              r_last_use;

    pgrepl_pkg::t_scan_flags        r_flags;
    logic [pgrepl_pkg::FRAME_W-1:0] r_hit_frame;
    logic [TIME_W-1:0]              r_lru_time;
    logic [PAGE_W-1:0]              r_lru_page;
    logic [pgrepl_pkg::FRAME_W-1:0] r_lru_frame;

    pgrepl_pkg::t_scan_flags        n_flags;
    logic [pgrepl_pkg::FRAME_W-1:0] n_hit_frame;
    logic [TIME_W-1:0]              n_lru_time;
    logic [PAGE_W-1:0]              n_lru_page;
    logic [pgrepl_pkg::FRAME_W-1:0] n_lru_frame;

    logic w_key_match;
    logic w_take_lru;

    always_comb begin
        w_key_match = r_resident && (i_key_page == MY_PAGE);
        // Strictly older wins, so on a tie the lower page number ahead stays.
        w_take_lru  = r_resident && (!i_flags.lru_found || (r_last_use < i_lru_time));

        n_flags            = i_flags;
        n_flags.hit        = i_flags.hit || w_key_match;
        n_flags.lru_found  = i_flags.lru_found || r_resident;
        n_flags.fifo_match = i_flags.fifo_match ||
                             (r_resident && (i_fifo_page == MY_PAGE) &&
                              (r_frame == i_fifo_frame));
        n_hit_frame = w_key_match ? r_frame    : i_hit_frame;
        n_lru_time  = w_take_lru  ? r_last_use : i_lru_time;
        n_lru_page  = w_take_lru  ? MY_PAGE    : i_lru_page;
        n_lru_frame = w_take_lru  ? r_frame    : i_lru_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resident <= 1'b0;
        end else if (i_wr.clear) begin
            r_resident <= 1'b0;
        end else if (i_wr.load && (i_wr_page == MY_PAGE)) begin
            r_resident <= 1'b1;
        end else if (i_wr.evict && (i_evict_page == MY_PAGE)) begin
            r_resident <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.load && (i_wr_page == MY_PAGE)) begin
            r_frame <= i_wr_frame;
        end
        if (i_wr.stamp && (i_wr_page == MY_PAGE)) begin
            r_last_use <= i_wr_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_frame <= n_hit_frame;
        r_lru_time  <= n_lru_time;
        r_lru_page  <= n_lru_page;
        r_lru_frame <= n_lru_frame;
    end

    assign o_flags     = r_flags;
    assign o_hit_frame = r_hit_frame;
    assign o_lru_time  = r_lru_time;
    assign o_lru_page  = r_lru_page;
    assign o_lru_frame = r_lru_frame;

endmodule

FILE: src/page_replacement_fifo_lru.sv
// An accepted reference is registered, launched into the row of page cells, captured from
// the tail and committed to the result register; the commit waits while the receiver stalls.
// The input is stalled until that commit, so no new reference is taken meanwhile; the search
// beat must walk the whole row of page cells, one cell per cycle, for every reference.
// Reset (synchronous, active low): all pages non-resident, counters and FIFO head zero,
// policy FIFO, four frames. Frame, stamp and load-order tables are not cleared.
module page_replacement_fifo_lru #(
    parameter int VIRTUAL_PAGES = pgrepl_pkg::DEF_VIRTUAL_PAGES,
    parameter int TIME_BITS     = pgrepl_pkg::DEF_TIME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Reference input channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [pgrepl_pkg::PAGE_IN_W-1:0]    i_page_number,
    input  logic                                i_restart,
    // Result output channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [pgrepl_pkg::FRAME_W-1:0]      o_frame,
    output logic                                o_evicted_valid,
    output logic [pgrepl_pkg::PAGE_IN_W-1:0]    o_evicted_page,
    output logic [pgrepl_pkg::FAULT_W-1:0]      o_fault_count,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pgrepl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pgrepl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pgrepl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int PAGE_W    = $clog2(VIRTUAL_PAGES);
    localparam int FRAME_CAP = (VIRTUAL_PAGES < pgrepl_pkg::FRAME_LIMIT) ?
                               VIRTUAL_PAGES : pgrepl_pkg::FRAME_LIMIT;
    localparam int WRAP_N    = 1 << pgrepl_pkg::PAGE_IN_W;
    localparam int FW        = pgrepl_pkg::FRAME_W;
    localparam int NW        = pgrepl_pkg::FRAMES_W;

    // ------------------------------------------------------------------
    // Configuration registers; bus writes land in the access phase. The
    // controller reads them: write only between references (unchecked).
    // ------------------------------------------------------------------
    logic          r_policy_mode;
    logic [NW-1:0] r_frames_in_use;
    logic          w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_mode   <= pgrepl_pkg::POLICY_FIFO;
            r_frames_in_use <= pgrepl_pkg::FRAMES_RESET;
        end else if (w_cfg_write) begin
            unique case (pgrepl_pkg::t_reg_idx'(paddr[2]))
                pgrepl_pkg::REG_POLICY_MODE:   r_policy_mode   <= pwdata[0];
                pgrepl_pkg::REG_FRAMES_IN_USE: r_frames_in_use <= pwdata[NW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (pgrepl_pkg::t_reg_idx'(paddr[2]))
            pgrepl_pkg::REG_POLICY_MODE:
                prdata = {{(pgrepl_pkg::APB_DATA_W-1){1'b0}}, r_policy_mode};
            pgrepl_pkg::REG_FRAMES_IN_USE:
                prdata = {{(pgrepl_pkg::APB_DATA_W-NW){1'b0}}, r_frames_in_use};
        endcase
    end

    // ------------------------------------------------------------------
    // Page number wrap. Each entry of this small table is the input page
    // reduced modulo the page count, settled at elaboration.
    // ------------------------------------------------------------------
    logic [PAGE_W-1:0] w_wrap_tab [WRAP_N];

    for (genvar v = 0; v < WRAP_N; v++) begin : g_wrap
        localparam int WRAPPED = v % VIRTUAL_PAGES;
        assign w_wrap_tab[v] = PAGE_W'(WRAPPED);
    end

    // ------------------------------------------------------------------
    // Control state and table-wide registers.
    // ------------------------------------------------------------------
    pgrepl_pkg::t_state r_state;
    pgrepl_pkg::t_state n_state;

    logic [PAGE_W-1:0]             r_page;
    logic [FW-1:0]                 r_order_head;
    logic [NW-1:0]                 r_next_free;
    logic [TIME_BITS-1:0]          r_now;
    logic [pgrepl_pkg::FAULT_W-1:0] r_faults;
    logic [PAGE_W-1:0]             r_load_order [pgrepl_pkg::FRAME_LIMIT];

    // Search results captured from the tail of the cell row.
    logic          r_res_hit;
    logic [FW-1:0] r_res_hit_frame;
    logic          r_res_lru_found;
    logic [PAGE_W-1:0] r_res_lru_page;
    logic [FW-1:0] r_res_lru_frame;
    logic          r_res_fifo_match;

    // Result register that parts the cell row from the output channel.
    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [FW-1:0]                  r_out_frame;
    logic                           r_out_evicted_valid;
    logic [pgrepl_pkg::PAGE_IN_W-1:0] r_out_evicted_page;
    logic [pgrepl_pkg::FAULT_W-1:0] r_out_fault_count;

    logic w_accept;
    logic w_slot_free;
    logic w_commit;
    logic w_launch;

    // Replacement decision outputs.
    logic [FW-1:0]     w_frame;
    logic              w_ev_valid;
    logic [PAGE_W-1:0] w_ev_page;
    logic              w_use_free;
    logic              w_use_fifo;

    // ------------------------------------------------------------------
    // The row of page cells. Tap 0 is fed by the controller; the beat
    // leaves the last cell after passing the register of every cell.
    // ------------------------------------------------------------------
    pgrepl_pkg::t_scan_flags w_flags      [VIRTUAL_PAGES+1];
    logic [FW-1:0]           w_hit_frame  [VIRTUAL_PAGES+1];
    logic [TIME_BITS-1:0]    w_lru_time   [VIRTUAL_PAGES+1];
    logic [PAGE_W-1:0]       w_lru_page   [VIRTUAL_PAGES+1];
    logic [FW-1:0]           w_lru_frame  [VIRTUAL_PAGES+1];
    logic [VIRTUAL_PAGES-1:0] w_chain_valid;

    pgrepl_pkg::t_cell_wr    w_wr;
    logic [PAGE_W-1:0]       w_evict_page_idx;

    // FIFO victim, worked out from registers that hold still during a search.
    // The page loaded in the victim frame is read out when the reference is
    // accepted; after a restart every frame is free, so that read goes unused.
    logic [NW-1:0]     w_eff;
    logic [FW-1:0]     w_victim;
    logic [NW-1:0]     w_victim_inc;
    logic [FW-1:0]     w_head_next;
    logic [PAGE_W-1:0] r_fifo_page;

    assign w_flags[0]     = '{valid: w_launch, hit: 1'b0, lru_found: 1'b0, fifo_match: 1'b0};
    assign w_hit_frame[0] = '0;
    assign w_lru_time[0]  = '0;
    assign w_lru_page[0]  = '0;
    assign w_lru_frame[0] = '0;

    for (genvar c = 0; c < VIRTUAL_PAGES; c++) begin : g_cell
        pgrepl_cell #(
            .CELL_ID (c),
            .PAGE_W  (PAGE_W),
            .TIME_W  (TIME_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_key_page   (r_page),
            .i_fifo_page  (r_fifo_page),
            .i_fifo_frame (w_victim),
            .i_flags      (w_flags[c]),
            .i_hit_frame  (w_hit_frame[c]),
            .i_lru_time   (w_lru_time[c]),
            .i_lru_page   (w_lru_page[c]),
            .i_lru_frame  (w_lru_frame[c]),
            .o_flags      (w_flags[c+1]),
            .o_hit_frame  (w_hit_frame[c+1]),
            .o_lru_time   (w_lru_time[c+1]),
            .o_lru_page   (w_lru_page[c+1]),
            .o_lru_frame  (w_lru_frame[c+1]),
            .i_wr         (w_wr),
            .i_wr_page    (r_page),
            .i_evict_page (w_evict_page_idx),
            .i_wr_frame   (w_frame),
            .i_wr_time    (r_now)
        );
        assign w_chain_valid[c] = w_flags[c+1].valid;
    end

    // ------------------------------------------------------------------
    // State machine: accept, launch the search beat, wait for it at the
    // tail, then commit once the result register can take the result.
    // ------------------------------------------------------------------
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_accept    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgrepl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_stall  = 1'b1;
        w_launch = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            pgrepl_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = pgrepl_pkg::ST_LAUNCH;
                end
            end
            pgrepl_pkg::ST_LAUNCH: begin
                w_launch = 1'b1;
                n_state  = pgrepl_pkg::ST_SCAN;
            end
            pgrepl_pkg::ST_SCAN: begin
                if (w_flags[VIRTUAL_PAGES].valid) begin
                    n_state = pgrepl_pkg::ST_FINISH;
                end
            end
            pgrepl_pkg::ST_FINISH: begin
                if (w_slot_free) begin
                    w_commit = 1'b1;
                    n_state  = pgrepl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pgrepl_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Replacement decision. A hit keeps its frame; a miss takes the next
    // free frame while any remain, else evicts by the selected policy.
    // ------------------------------------------------------------------
    always_comb begin
        // A zero count acts as one frame; anything above the cap acts as the cap.
        if (r_frames_in_use == '0) begin
            w_eff = NW'(1);
        end else if (r_frames_in_use > NW'(FRAME_CAP)) begin
            w_eff = NW'(FRAME_CAP);
        end else begin
            w_eff = r_frames_in_use;
        end

        // A head at or beyond a lowered frame count restarts at frame 0.
        w_victim     = ({1'b0, r_order_head} < w_eff) ? r_order_head : '0;
        w_victim_inc = {1'b0, w_victim} + NW'(1);
        w_head_next  = (w_victim_inc < w_eff) ? w_victim_inc[FW-1:0] : '0;

        w_frame    = r_res_hit_frame;
        w_ev_valid = 1'b0;
        w_ev_page  = '0;
        w_use_free = 1'b0;
        w_use_fifo = 1'b0;
        if (!r_res_hit) begin
            if (r_next_free < w_eff) begin
                w_use_free = 1'b1;
                w_frame    = r_next_free[FW-1:0];
            end else if (r_policy_mode == pgrepl_pkg::POLICY_FIFO) begin
                // The victim frame may hold no live page; then it is reused quietly.
                w_use_fifo = 1'b1;
                w_frame    = w_victim;
                w_ev_valid = r_res_fifo_match;
                w_ev_page  = r_res_fifo_match ? r_fifo_page : '0;
            end else if (r_res_lru_found) begin
                w_frame    = r_res_lru_frame;
                w_ev_valid = 1'b1;
                w_ev_page  = r_res_lru_page;
            end else begin
                // Nothing resident under LRU: frame 0 is reused.
                w_frame = '0;
            end
        end
    end

    // Restart clears residency at the accept edge, before the search starts.
    always_comb begin
        w_wr.clear       = w_accept && i_restart;
        w_wr.evict       = w_commit && w_ev_valid;
        w_wr.load        = w_commit && !r_res_hit;
        w_wr.stamp       = w_commit;
        w_evict_page_idx = w_ev_page;
    end

    // ------------------------------------------------------------------
    // Table-wide counters, load order and captured search results.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_head <= '0;
            r_next_free  <= '0;
            r_now        <= '0;
            r_faults     <= '0;
        end else if (w_accept && i_restart) begin
            r_order_head <= '0;
            r_next_free  <= '0;
            r_now        <= '0;
            r_faults     <= '0;
        end else if (w_commit) begin
            if (!r_res_hit && (r_faults != pgrepl_pkg::FAULT_MAX)) begin
                r_faults <= r_faults + pgrepl_pkg::FAULT_W'(1);
            end
            if (w_use_free) begin
                r_next_free <= r_next_free + NW'(1);
            end
            if (w_use_fifo) begin
                r_order_head <= w_head_next;
            end
            if (r_now != '1) begin
                r_now <= r_now + TIME_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page      <= w_wrap_tab[i_page_number];
            r_fifo_page <= r_load_order[w_victim];
        end
        if (w_commit && !r_res_hit) begin
            r_load_order[w_frame] <= r_page;
        end
        if ((r_state == pgrepl_pkg::ST_SCAN) && w_flags[VIRTUAL_PAGES].valid) begin
            r_res_hit        <= w_flags[VIRTUAL_PAGES].hit;
            r_res_hit_frame  <= w_hit_frame[VIRTUAL_PAGES];
            r_res_lru_found  <= w_flags[VIRTUAL_PAGES].lru_found;
            r_res_lru_page   <= w_lru_page[VIRTUAL_PAGES];
            r_res_lru_frame  <= w_lru_frame[VIRTUAL_PAGES];
            r_res_fifo_match <= w_flags[VIRTUAL_PAGES].fifo_match;
        end
    end

    // ------------------------------------------------------------------
    // Output register. The fault count shown includes this reference.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_hit           <= r_res_hit;
            r_out_frame         <= w_frame;
            r_out_evicted_valid <= w_ev_valid;
            r_out_evicted_page  <= pgrepl_pkg::PAGE_IN_W'(w_ev_page);
            if (!r_res_hit && (r_faults != pgrepl_pkg::FAULT_MAX)) begin
                r_out_fault_count <= r_faults + pgrepl_pkg::FAULT_W'(1);
            end else begin
                r_out_fault_count <= r_faults;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame         = r_out_frame;
    assign o_evicted_valid = r_out_evicted_valid;
    assign o_evicted_page  = r_out_evicted_page;
    assign o_fault_count   = r_out_fault_count;

`ifndef NO_ASSERTIONS
    // Only one search beat may be in the row at a time.
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_chain_valid))
        else $error("more than one search beat in the cell row");

    // The beat reaches the tail only while the controller waits for it.
    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flags[VIRTUAL_PAGES].valid |-> (r_state == pgrepl_pkg::ST_SCAN))
        else $error("search beat left the row outside the scan state");

    // Every resident page was stamped since the last restart, so never later than now.
    a_stamp_past: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_flags[VIRTUAL_PAGES].valid && w_flags[VIRTUAL_PAGES].lru_found)
            |-> (w_lru_time[VIRTUAL_PAGES] <= r_now))
        else $error("oldest stamp lies ahead of the reference clock");

    // Free frames are handed out no further than the frame limit.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NW'(FRAME_CAP))
        else $error("free frame count passed the frame limit");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |-> !r_out_evicted_valid)
        else $error("eviction reported on a hit");
`endif

endmodule
